// ===== rtl/fdpr_pkg.sv =====
// fdpr_pkg: widths, register codes, shared types and the sine table generator
// for the four-d plane rotation block. Depends on nothing; every rtl file uses it.
package fdpr_pkg;

   localparam int COORD_W     = 32;
   localparam int TRIG_W      = 16;
   localparam int PROD_W      = COORD_W + TRIG_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int IDX_W       = 2;
   localparam int NUM_COORDS  = 4;
   localparam int FRAC_SHIFT  = 15;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = IDX_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_FIRST  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_SECOND = 1'd1;

   localparam logic [IDX_W-1:0] PLANE_FIRST_RST  = 2'd1;
   localparam logic [IDX_W-1:0] PLANE_SECOND_RST = 2'd2;

   localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd32767;

   localparam logic [63:0] HALF_PI_Q61 = 64'h3243F6A8885A308D;
   localparam logic [63:0] ONE_Q61     = 64'h2000000000000000;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type point_type [NUM_COORDS];
   typedef logic signed [TRIG_W-1:0] trig_type;

   typedef struct packed {
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
   } plane_type;

   // low 64 bits of (a*b) >> sh
   function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      return p[63:0];
   endfunction

   // floor(n / d) by shift and subtract, only used while building the table
   function automatic logic [63:0] div_floor(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // q61 magnitude in [0,1] to rounded q1.15 magnitude, up to 32768
   function automatic logic [TRIG_W-1:0] q61_to_q15(input logic [63:0] v);
      logic [63:0] t;
      t = v[63] ? 64'd0 : v;
      t = (t + (64'd1 << 45)) >> 46;
      return t[TRIG_W-1:0];
   endfunction

   // {sin, cos} magnitudes of a quarter turn times r / 2^(angle_bits-2)
   function automatic logic [2*TRIG_W-1:0] sincos_entry(input int unsigned r,
                                                        input int unsigned angle_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] ts;
      logic [63:0] tc;
      logic [63:0] ss;
      logic [63:0] sc;
      logic [63:0] den_s;
      logic [63:0] den_c;
      x  = mul_shift(HALF_PI_Q61, 64'(r), angle_bits - 2);
      x2 = mul_shift(x, x, 61);
      ts = x;
      ss = x;
      tc = ONE_Q61;
      sc = ONE_Q61;
      for (int unsigned k = 1; k <= 14; k++) begin
         den_s = 64'((2 * k) * (2 * k + 1));
         den_c = 64'((2 * k - 1) * (2 * k));
         ts = div_floor(mul_shift(ts, x2, 61), den_s);
         tc = div_floor(mul_shift(tc, x2, 61), den_c);
         if (k[0]) begin
            ss = ss - ts;
            sc = sc - tc;
         end else begin
            ss = ss + ts;
            sc = sc + tc;
         end
      end
      return {q61_to_q15(ss), q61_to_q15(sc)};
   endfunction

endpackage

// ===== rtl/fdpr_if.sv =====
// fdpr_req_if / fdpr_rsp_if: valid-ready channels for points in and rotated points out.
// Depends on fdpr_pkg for the coordinate type.
interface fdpr_req_if #(parameter int ANGLE_BITS = 12);
   logic                      valid;
   logic                      ready;
   logic [ANGLE_BITS-1:0]     angle;
   fdpr_pkg::coord_type       x0;
   fdpr_pkg::coord_type       x1;
   fdpr_pkg::coord_type       x2;
   fdpr_pkg::coord_type       x3;

   modport source (output valid, angle, x0, x1, x2, x3, input ready);
   modport sink   (input valid, angle, x0, x1, x2, x3, output ready);
endinterface

interface fdpr_rsp_if;
   logic                      valid;
   logic                      ready;
   fdpr_pkg::coord_type       y0;
   fdpr_pkg::coord_type       y1;
   fdpr_pkg::coord_type       y2;
   fdpr_pkg::coord_type       y3;

   modport source (output valid, y0, y1, y2, y3, input ready);
   modport sink   (input valid, y0, y1, y2, y3, output ready);
endinterface

// ===== rtl/fdpr_sincos.sv =====
// fdpr_sincos: two pipeline stages that turn an angle into signed q1.15 cos and sin,
// carrying the point along. Depends on fdpr_pkg (table generator, types).
module fdpr_sincos #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [ANGLE_BITS-1:0]   angle,
   input  fdpr_pkg::point_type     pt,
   output logic                    out_valid,
   input  logic                    out_ready,
   output fdpr_pkg::trig_type      c,
   output fdpr_pkg::trig_type      s,
   output fdpr_pkg::point_type     pt_out
);

   localparam int REM_W  = ANGLE_BITS - 2;
   localparam int QDEPTH = 2 ** REM_W;
   localparam int TW     = fdpr_pkg::TRIG_W;

   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;

   logic [2*TW-1:0] rom_w [QDEPTH];

   for (genvar g = 0; g < QDEPTH; g++) begin : g_rom
      localparam logic [2*TW-1:0] ENTRY =
         fdpr_pkg::sincos_entry(32'(g), 32'(ANGLE_BITS));
      assign rom_w[g] = ENTRY;
   end

   logic [1:0]          v_ff;
   logic [1:0]          v_in;
   logic [1:0]          adv;

   logic [2*TW-1:0]     rom_ff;
   logic [1:0]          quad_ff;
   fdpr_pkg::point_type pt0_ff;

   fdpr_pkg::trig_type  c_ff;
   fdpr_pkg::trig_type  s_ff;
   fdpr_pkg::trig_type  c_in;
   fdpr_pkg::trig_type  s_in;
   fdpr_pkg::point_type pt1_ff;

   logic signed [TW:0]  sm;
   logic signed [TW:0]  cm;
   logic signed [TW:0]  sv;
   logic signed [TW:0]  cv;

   function automatic fdpr_pkg::trig_type sat_trig(input logic signed [TW:0] v);
      return (!v[TW] && v[TW-1]) ? fdpr_pkg::TRIG_MAX : v[TW-1:0];
   endfunction

   assign adv[1]   = !v_ff[1] || out_ready;
   assign adv[0]   = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   assign v_in[0] = adv[0] ? in_valid : v_ff[0];
   assign v_in[1] = adv[1] ? v_ff[0] : v_ff[1];

   // quadrant fold of the quarter-turn magnitudes
   always_comb begin
      sm = $signed({1'b0, rom_ff[2*TW-1:TW]});
      cm = $signed({1'b0, rom_ff[TW-1:0]});
      case (quad_ff)
         QUAD_FIRST: begin
            sv = sm;
            cv = cm;
         end
         QUAD_SECOND: begin
            sv = cm;
            cv = -sm;
         end
         QUAD_THIRD: begin
            sv = -sm;
            cv = -cm;
         end
         default: begin
            sv = -cm;
            cv = sm;
         end
      endcase
      s_in = sat_trig(sv);
      c_in = sat_trig(cv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (adv[0]) begin
         rom_ff  <= rom_w[angle[REM_W-1:0]];
         quad_ff <= angle[ANGLE_BITS-1:REM_W];
         pt0_ff  <= pt;
      end
      if (adv[1]) begin
         c_ff   <= c_in;
         s_ff   <= s_in;
         pt1_ff <= pt0_ff;
      end
   end

   assign out_valid = v_ff[1];
   assign c         = c_ff;
   assign s         = s_ff;
   assign pt_out    = pt1_ff;

   a_zero_angle: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && angle == '0 && !v_ff[0] && !v_ff[1]) |->
         ##2 (out_valid && c == fdpr_pkg::TRIG_MAX && s == '0))
      else $error("zero angle did not give unit cosine");

   a_nonzero_pair: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (c != '0 || s != '0))
      else $error("cosine and sine both zero");

endmodule

// ===== rtl/fdpr_rotate.sv =====
// fdpr_rotate: three pipeline stages (products, sums, round and saturate) that
// rotate the point in the selected plane. Depends on fdpr_pkg.
module fdpr_rotate (
   input  logic                    clock,
   input  logic                    reset,
   input  fdpr_pkg::plane_type     plane,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  fdpr_pkg::trig_type      c,
   input  fdpr_pkg::trig_type      s,
   input  fdpr_pkg::point_type     pt,
   output logic                    out_valid,
   input  logic                    out_ready,
   output fdpr_pkg::point_type     y
);

   localparam int PW = fdpr_pkg::PROD_W;
   localparam int SW = fdpr_pkg::SUM_W;
   localparam int CW = fdpr_pkg::COORD_W;
   localparam int QW = SW + 1 - fdpr_pkg::FRAC_SHIFT;

   logic [2:0]             v_ff;
   logic [2:0]             v_in;
   logic [2:0]             adv;

   fdpr_pkg::coord_type    xa;
   fdpr_pkg::coord_type    xb;
   logic signed [PW-1:0]   ca_ff, sb_ff, sa_ff, cb_ff;
   logic signed [PW-1:0]   ca_in, sb_in, sa_in, cb_in;
   fdpr_pkg::point_type    ptp_ff;

   logic signed [SW-1:0]   suma_ff, sumb_ff;
   logic signed [SW-1:0]   suma_in, sumb_in;
   fdpr_pkg::point_type    pts_ff;

   fdpr_pkg::point_type    y_ff;
   fdpr_pkg::point_type    y_in;

   // floor((sum + 2^14) / 2^15), clamped to 32 bits
   function automatic fdpr_pkg::coord_type round_sat(input logic signed [SW-1:0] sum);
      logic signed [SW:0]   t;
      logic signed [QW-1:0] q;
      t = (SW + 1)'(sum) + (SW + 1)'(1 << (fdpr_pkg::FRAC_SHIFT - 1));
      q = $signed(t[SW:fdpr_pkg::FRAC_SHIFT]);
      if (q[QW-1:CW-1] == '0 || q[QW-1:CW-1] == '1) begin
         return q[CW-1:0];
      end else if (q[QW-1]) begin
         return {1'b1, {(CW - 1){1'b0}}};
      end else begin
         return {1'b0, {(CW - 1){1'b1}}};
      end
   endfunction

   assign adv[2]   = !v_ff[2] || out_ready;
   assign adv[1]   = !v_ff[1] || adv[2];
   assign adv[0]   = !v_ff[0] || adv[1];
   assign in_ready = adv[0];

   assign v_in[0] = adv[0] ? in_valid : v_ff[0];
   assign v_in[1] = adv[1] ? v_ff[0] : v_ff[1];
   assign v_in[2] = adv[2] ? v_ff[1] : v_ff[2];

   // equal plane indices give xb == xa, so the first rule becomes (c-s)*xa
   always_comb begin
      xa    = pt[plane.first];
      xb    = pt[plane.second];
      ca_in = PW'(c) * PW'(xa);
      sb_in = PW'(s) * PW'(xb);
      sa_in = PW'(s) * PW'(xa);
      cb_in = PW'(c) * PW'(xb);
   end

   assign suma_in = SW'(ca_ff) - SW'(sb_ff);
   assign sumb_in = SW'(sa_ff) + SW'(cb_ff);

   always_comb begin
      for (int i = 0; i < fdpr_pkg::NUM_COORDS; i++) begin
         if (plane.first == fdpr_pkg::IDX_W'(i)) begin
            y_in[i] = round_sat(suma_ff);
         end else if (plane.second == fdpr_pkg::IDX_W'(i)) begin
            y_in[i] = round_sat(sumb_ff);
         end else begin
            y_in[i] = pts_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
      if (adv[0]) begin
         ca_ff  <= ca_in;
         sb_ff  <= sb_in;
         sa_ff  <= sa_in;
         cb_ff  <= cb_in;
         ptp_ff <= pt;
      end
      if (adv[1]) begin
         suma_ff <= suma_in;
         sumb_ff <= sumb_in;
         pts_ff  <= ptp_ff;
      end
      if (adv[2]) begin
         y_ff <= y_in;
      end
   end

   assign out_valid = v_ff[2];
   assign y         = y_ff;

   a_fill_latency: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready && v_ff == '0) |-> ##3 out_valid)
      else $error("item lost in rotation stages");

endmodule

// ===== rtl/four_d_plane_rotation_top.sv =====
// four_d_plane_rotation_top: rotates a 4d q16.16 point in a configurable coordinate plane.
// Depends on fdpr_pkg, fdpr_if, fdpr_sincos and fdpr_rotate.
//
// req_ch carries an angle (fraction of a full turn, ANGLE_BITS wide) and the point x0..x3;
// rsp_ch returns the rotated point y0..y3, one item per request item, in order.
// csr_we/csr_index/csr_wdata write the plane indices: index 0 is the first coordinate,
// index 1 the second. Write them only while no item is in flight.
// From request accept to response valid an item passes two stages for the angle
// (quarter-wave table read, quadrant fold) and three for the rotation (products, sums,
// round and saturate). While rsp_ch is ready one item per cycle is sustained; the 16x32
// multipliers and the 2^(ANGLE_BITS-2) entry quarter-wave table each sit in a stage
// of their own. Each stage has its own valid bit, so bubbles are squeezed out and req_ch
// stays ready while any stage is empty, even when rsp_ch is stalled. A stalled response
// holds. Synchronous reset empties the pipeline and sets the plane to coordinates 1 and 2.
module four_d_plane_rotation_top #(
   parameter int ANGLE_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   fdpr_req_if.sink                             req_ch,
   fdpr_rsp_if.source                           rsp_ch,
   input  logic                                 csr_we,
   input  logic [fdpr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fdpr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int PIPE_DEPTH = 5;
   localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

   fdpr_pkg::plane_type plane_ff;
   fdpr_pkg::plane_type plane_in;

   fdpr_pkg::point_type pt_req;
   fdpr_pkg::point_type pt_mid;
   fdpr_pkg::point_type pt_rsp;
   fdpr_pkg::trig_type  c_mid;
   fdpr_pkg::trig_type  s_mid;
   logic                mid_valid;
   logic                mid_ready;

   logic [CNT_W-1:0]    inflight_ff;
   logic [CNT_W-1:0]    inflight_in;
   logic                req_acc;
   logic                rsp_acc;

   always_comb begin
      plane_in = plane_ff;
      if (csr_we) begin
         case (csr_index)
            fdpr_pkg::CSR_PLANE_FIRST:  plane_in.first  = csr_wdata;
            fdpr_pkg::CSR_PLANE_SECOND: plane_in.second = csr_wdata;
            default:                    plane_in        = plane_ff;
         endcase
      end
   end

   assign req_acc     = req_ch.valid && req_ch.ready;
   assign rsp_acc     = rsp_ch.valid && rsp_ch.ready;
   assign inflight_in = inflight_ff + CNT_W'(req_acc) - CNT_W'(rsp_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.first  <= fdpr_pkg::PLANE_FIRST_RST;
         plane_ff.second <= fdpr_pkg::PLANE_SECOND_RST;
         inflight_ff     <= '0;
      end else begin
         plane_ff    <= plane_in;
         inflight_ff <= inflight_in;
      end
   end

   assign pt_req[0] = req_ch.x0;
   assign pt_req[1] = req_ch.x1;
   assign pt_req[2] = req_ch.x2;
   assign pt_req[3] = req_ch.x3;

   fdpr_sincos #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_sincos (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .angle     (req_ch.angle[ANGLE_BITS-1:0]),
      .pt        (pt_req),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .c         (c_mid),
      .s         (s_mid),
      .pt_out    (pt_mid)
   );

   fdpr_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .plane     (plane_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .c         (c_mid),
      .s         (s_mid),
      .pt        (pt_mid),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .y         (pt_rsp)
   );

   assign rsp_ch.y0 = pt_rsp[0];
   assign rsp_ch.y1 = pt_rsp[1];
   assign rsp_ch.y2 = pt_rsp[2];
   assign rsp_ch.y3 = pt_rsp[3];

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> inflight_ff != '0)
      else $error("response valid with no item in flight");

endmodule

// ===== tb/sv/four_d_plane_rotation_top_tb.sv =====
`timescale 1ns / 100ps
// four_d_plane_rotation_top_tb: streams q16.16 points through the plane rotation block
// under random valid/ready gaps and checks every rotated point against a q1.15 predictor.
// Depends on fdpr_pkg, fdpr_if and the rtl below four_d_plane_rotation_top.
module four_d_plane_rotation_top_tb;

   localparam int ANGLE_BITS    = 12;
   localparam int QUARTER_STEPS = 1 << (ANGLE_BITS - 2);
   localparam int IDLE_LIMIT    = 1000;
   localparam int PHASE_ITEMS   = 110;
   localparam int RANDOM_PHASES = 8;

   localparam logic [63:0]         QUARTER_TURN_Q61 = 64'h3243F6A8885A308D;
   localparam logic [63:0]         UNITY_Q61        = 64'h2000000000000000;
   localparam fdpr_pkg::coord_type COORD_MAX        = 32'sh7FFFFFFF;
   localparam fdpr_pkg::coord_type COORD_MIN        = 32'sh80000000;

   typedef logic [fdpr_pkg::NUM_COORDS-1:0][fdpr_pkg::COORD_W-1:0] point_vec_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle;
      point_vec_type         x;
   } point_in_type;

   class point_rotation_checker;
      int                         sin_q15 [QUARTER_STEPS];
      int                         cos_q15 [QUARTER_STEPS];
      logic [fdpr_pkg::IDX_W-1:0] axis_a;
      logic [fdpr_pkg::IDX_W-1:0] axis_b;
      point_vec_type              expected_points [$];
      int                         mismatches;
      int                         rotated;

      // quarter-wave sin/cos by taylor series in q61, rounded to q1.15 magnitudes
      function new();
         logic [127:0] wide;
         logic [63:0]  phi;
         logic [63:0]  phi_sq;
         logic [63:0]  term_s;
         logic [63:0]  term_c;
         logic [63:0]  acc_s;
         logic [63:0]  acc_c;
         axis_a     = 2'd1;
         axis_b     = 2'd2;
         mismatches = 0;
         rotated    = 0;
         for (int r = 0; r < QUARTER_STEPS; r++) begin
            wide   = {64'd0, QUARTER_TURN_Q61} * 128'(r);
            phi    = 64'(wide >> (ANGLE_BITS - 2));
            wide   = {64'd0, phi} * {64'd0, phi};
            phi_sq = 64'(wide >> 61);
            term_s = phi;
            acc_s  = phi;
            term_c = UNITY_Q61;
            acc_c  = UNITY_Q61;
            for (int k = 1; k <= 14; k++) begin
               wide   = {64'd0, term_s} * {64'd0, phi_sq};
               term_s = 64'(wide >> 61) / 64'((2 * k) * (2 * k + 1));
               wide   = {64'd0, term_c} * {64'd0, phi_sq};
               term_c = 64'(wide >> 61) / 64'((2 * k - 1) * (2 * k));
               if (k % 2 == 1) begin
                  acc_s = acc_s - term_s;
                  acc_c = acc_c - term_c;
               end else begin
                  acc_s = acc_s + term_s;
                  acc_c = acc_c + term_c;
               end
            end
            sin_q15[r] = q15_of(acc_s);
            cos_q15[r] = q15_of(acc_c);
         end
      endfunction

      function int q15_of(logic [63:0] v);
         logic [63:0] t;
         t = v[63] ? 64'd0 : v + (64'd1 << 45);
         return int'(t >> 46);
      endfunction

      function longint round_sat(longint acc);
         longint r;
         r = (acc + 16384) >>> 15;
         if (r > 64'sd2147483647)
            return 64'sd2147483647;
         if (r < -64'sd2147483648)
            return -64'sd2147483648;
         return r;
      endfunction

      function void set_plane(logic [fdpr_pkg::IDX_W-1:0] a, logic [fdpr_pkg::IDX_W-1:0] b);
         axis_a = a;
         axis_b = b;
      endfunction

      function point_vec_type predict_point(point_in_type p);
         logic [ANGLE_BITS-3:0] step;
         longint                sn;
         longint                cs;
         longint                s;
         longint                c;
         longint                xs [fdpr_pkg::NUM_COORDS];
         point_vec_type         y;
         step = p.angle[ANGLE_BITS-3:0];
         sn   = sin_q15[step];
         cs   = cos_q15[step];
         case (p.angle[ANGLE_BITS-1 -: 2])
            2'd0: begin s = sn;  c = cs;  end
            2'd1: begin s = cs;  c = -sn; end
            2'd2: begin s = -sn; c = -cs; end
            default: begin s = -cs; c = sn; end
         endcase
         // +1.0 has no q1.15 code, -1.0 does
         if (s > 32767) s = 32767;
         if (c > 32767) c = 32767;
         for (int i = 0; i < fdpr_pkg::NUM_COORDS; i++)
            xs[i] = longint'($signed(p.x[i]));
         y = p.x;
         y[axis_a] = 32'(round_sat(c * xs[axis_a] - s * xs[axis_b]));
         if (axis_b != axis_a)
            y[axis_b] = 32'(round_sat(s * xs[axis_a] + c * xs[axis_b]));
         return y;
      endfunction

      function void note_point(point_in_type p);
         expected_points.push_back(predict_point(p));
      endfunction

      function void check_rotated(point_vec_type got);
         point_vec_type want;
         if (expected_points.size() == 0) begin
            $error("rotated point with no item pending: y0 %0d y1 %0d y2 %0d y3 %0d",
                   $signed(got[0]), $signed(got[1]), $signed(got[2]), $signed(got[3]));
            mismatches++;
            return;
         end
         want = expected_points.pop_front();
         rotated++;
         for (int i = 0; i < fdpr_pkg::NUM_COORDS; i++) begin
            if (got[i] !== want[i]) begin
               $error("y%0d expected %0d got %0d", i, $signed(want[i]), $signed(got[i]));
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_we;
   logic [fdpr_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [fdpr_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                             steady = 1'b0;
   int                               idle_cycles = 0;
   int                               plane_settings = 0;
   point_rotation_checker            book;

   fdpr_req_if #(.ANGLE_BITS(ANGLE_BITS)) req_ch ();
   fdpr_rsp_if rsp_ch ();

   four_d_plane_rotation_top #(
      .ANGLE_BITS(ANGLE_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // ends the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("four_d_plane_rotation_top_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_point(input logic [ANGLE_BITS-1:0] turn,
                             input fdpr_pkg::coord_type x0, input fdpr_pkg::coord_type x1,
                             input fdpr_pkg::coord_type x2, input fdpr_pkg::coord_type x3);
      int           gap;
      point_in_type p;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.angle <= turn;
      req_ch.x0    <= x0;
      req_ch.x1    <= x1;
      req_ch.x2    <= x2;
      req_ch.x3    <= x3;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      p.angle = turn;
      p.x     = {x3, x2, x1, x0};
      book.note_point(p);
   endtask

   function automatic fdpr_pkg::coord_type random_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return $urandom_range(0, 2) - 1;
         3, 4: return $signed($urandom) >>> $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_point();
      logic [ANGLE_BITS-1:0] turn;
      // a quarter of the angles sit on or next to a quadrant boundary
      if ($urandom_range(0, 3) == 0)
         turn = ANGLE_BITS'($urandom_range(0, 3) * QUARTER_STEPS + $urandom_range(0, 2) - 1);
      else
         turn = ANGLE_BITS'($urandom);
      send_point(turn, random_coord(), random_coord(), random_coord(), random_coord());
   endtask

   task automatic write_plane(input logic [fdpr_pkg::IDX_W-1:0] a,
                              input logic [fdpr_pkg::IDX_W-1:0] b);
      csr_we    <= 1'b1;
      csr_index <= fdpr_pkg::CSR_PLANE_FIRST;
      csr_wdata <= a;
      @(posedge clock);
      csr_index <= fdpr_pkg::CSR_PLANE_SECOND;
      csr_wdata <= b;
      @(posedge clock);
      csr_we <= 1'b0;
      book.set_plane(a, b);
      plane_settings++;
   endtask

   task automatic drain(input int settle);
      while (book.expected_points.size() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   initial begin : result_sink
      int            stall;
      point_vec_type got;
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = {rsp_ch.y3, rsp_ch.y2, rsp_ch.y1, rsp_ch.y0};
         book.check_rotated(got);
      end
   end

   initial begin : stimulus
      book = new();
      req_ch.valid <= 1'b0;
      req_ch.angle <= '0;
      req_ch.x0    <= '0;
      req_ch.x1    <= '0;
      req_ch.x2    <= '0;
      req_ch.x3    <= '0;
      csr_we       <= 1'b0;
      csr_index    <= fdpr_pkg::CSR_PLANE_FIRST;
      csr_wdata    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset plane (1, 2): quadrant edges, full-scale trig and saturation
      send_point(0,    32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000);
      send_point(1024, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000);
      send_point(2048, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000);
      send_point(3072, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000);
      send_point(4095, 32'sh10000, 32'sh20000, -32'sh30000, 32'sh40000);
      send_point(512,  0, COORD_MAX, COORD_MAX, 0);
      send_point(512,  0, COORD_MIN, COORD_MIN, 0);
      send_point(1536, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
      send_point(2048, 0, COORD_MIN, COORD_MAX, 0);
      send_point(1024, 0, COORD_MIN, COORD_MIN, 0);
      send_point(3072, 0, COORD_MAX, COORD_MIN, 0);
      send_point(1,    -1, -1, 1, 1);
      send_point(4095, COORD_MIN, 1, -1, COORD_MAX);
      send_point(256,  32'sd12345678, -32'sd87654321, 32'sh7FFF0000, -2);
      send_point(0,    COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_point(0,    COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      send_point(2047, 0, 32'sh10000, 32'sh10000, 0);
      send_point(3584, -5, 32'sd32767, -32'sd32768, 7);
      req_ch.valid <= 1'b0;
      drain(2);

      // equal plane indices: only the first rule applies
      write_plane(2'd3, 2'd3);
      send_point(0,    1, 2, 3, COORD_MAX);
      send_point(512,  0, 0, 0, COORD_MAX);
      send_point(1536, 0, 0, 0, COORD_MIN);
      send_point(2048, 5, 6, 7, COORD_MIN);
      send_point(3072, 5, 6, 7, -32'sh12345);
      send_point(4095, COORD_MIN, COORD_MAX, -1, 32'sh8000);
      req_ch.valid <= 1'b0;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain(2);
         steady = (ph % 3 == 2);
         case (ph)
            0: write_plane(2'd0, 2'd3);
            1: write_plane(2'd3, 2'd0);
            2: write_plane(2'd0, 2'd0);
            3: write_plane(2'd2, 2'd1);
            default: write_plane(2'($urandom), 2'($urandom));
         endcase
         repeat (PHASE_ITEMS) send_random_point();
         req_ch.valid <= 1'b0;
      end

      drain(8);
      $display("%0d points rotated and checked under %0d plane settings",
               book.rotated, plane_settings);
      $display("settings included both index orders, equal indices and the reset plane");
      if (book.mismatches == 0) begin
         $display("four_d_plane_rotation_top_tb OK");
      end else begin
         $display("four_d_plane_rotation_top_tb NOT OK");
      end
      $finish;
   end

endmodule
